/* rtl/rpfd_pkg.sv */
// ----------------------------------------------------------------------------
// rpfd_pkg: shared types and constants of the RGB fade dimmer
// Task codes, command modes, register indexes and the divider interface.
// ----------------------------------------------------------------------------
package rpfd_pkg;

    localparam int unsigned TimeW  = 24;
    localparam int unsigned LevelW = 8;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [2:0] {
        T_TASK_IDLE = 3'd0,
        T_TASK_STOP = 3'd1,
        T_TASK_ON   = 3'd2,
        T_TASK_OFF  = 3'd3,
        T_TASK_SET  = 3'd4,
        T_TASK_REL  = 3'd5
    } t_task;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_ON    = 3'd1,
        MODE_OFF   = 3'd2,
        MODE_SET   = 3'd3,
        MODE_REL   = 3'd4,
        MODE_NIGHT = 3'd5
    } t_mode;

    localparam logic [2:0] REG_FADE_ABS  = 3'd0;
    localparam logic [2:0] REG_FADE_REL  = 3'd1;
    localparam logic [2:0] REG_DAY       = 3'd2;
    localparam logic [2:0] REG_NIGHT     = 3'd3;
    localparam logic [2:0] REG_USE_DAY   = 3'd4;
    localparam logic [2:0] REG_USE_NIGHT = 3'd5;
    localparam logic [2:0] REG_MIN       = 3'd6;
    localparam logic [2:0] REG_MAX       = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [TimeW-1:0]  dividend;
        logic [LevelW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [TimeW-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/rpfd_if.sv */
// ----------------------------------------------------------------------------
// rpfd_cmd_if / rpfd_res_if: valid-ready channels of the fade dimmer
// Command item in, result item out.
// ----------------------------------------------------------------------------
interface rpfd_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [23:0] color;
    logic [1:0]  channel;
    logic        direction;
    logic [2:0]  step_size;
    logic        night;
    modport source (output valid, mode, color, channel, direction, step_size, night,
                    input ready);
    modport sink   (input valid, mode, color, channel, direction, step_size, night,
                    output ready);
endinterface

interface rpfd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       levels_changed;
    logic       status_report;
    logic       light_on;
    logic       busy_res;
    modport source (output valid, red, green, blue, levels_changed, status_report,
                    light_on, busy_res, input ready);
    modport sink   (input valid, red, green, blue, levels_changed, status_report,
                    light_on, busy_res, output ready);
endinterface

/* rtl/rgb_proportional_fade_dimmer_top.sv */
// A command, or a tick with a fade already latched, executes on acceptance and its result
// is registered; the tick that latches a fade first runs the serial divider in S_DIV.
// Throughput: one item at a time; the next is accepted once the result is transferred.
// The divider (one quotient bit per cycle) sets the step time at fade start.
// Reset (synchronous, active low) restores register defaults and idles all fade state.
// ----------------------------------------------------------------------------
// rgb_proportional_fade_dimmer_top: three-channel RGB fader
// Commands set targets; ticks step channels on Bresenham accumulators.
// ----------------------------------------------------------------------------
module rgb_proportional_fade_dimmer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rpfd_cmd_if.sink                     cmd,
    rpfd_res_if.source                   res,
    input  logic                         i_cfg_we,
    input  logic [rpfd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [rpfd_pkg::TimeW-1:0]   i_cfg_data
);
    import rpfd_pkg::*;

    // configuration registers
    logic [23:0] r_fade_abs, r_fade_rel, r_day, r_night;
    logic        r_use_day, r_use_night;
    logic [7:0]  r_min, r_max;

    // fade state
    logic [7:0]  r_cur [3];
    logic [7:0]  r_tgt [3];
    logic [7:0]  r_dlt [3];
    logic [8:0]  r_acc [3];
    logic [7:0]  r_big;
    logic [23:0] r_step_time, r_ticks;
    t_task       r_task;
    logic        r_started, r_is_night;
    logic [23:0] r_last_day, r_last_night;

    // held command and result
    logic [2:0]  r_mode;
    logic [23:0] r_color;
    logic [1:0]  r_chan;
    logic        r_dir;
    logic [2:0]  r_stepc;
    logic        r_nflag;
    logic        r_changed, r_report;

    t_state   r_state, n_state;
    t_div_req w_req;
    t_div_rsp w_rsp;

    logic w_accept, w_done;
    assign w_accept = cmd.valid && cmd.ready;
    assign w_done   = res.valid && res.ready;

    // a tick that must latch a fade runs the divider first
    logic w_need_div;
    assign w_need_div = (cmd.mode == MODE_TICK) && !r_started &&
                        (r_task == T_TASK_ON || r_task == T_TASK_OFF ||
                         r_task == T_TASK_SET || r_task == T_TASK_REL);

    // deltas from current levels, used when launching the divide
    logic [7:0] w_d [3];
    logic [7:0] w_max01, w_maxd;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = (r_cur[i] > r_tgt[i]) ? r_cur[i] - r_tgt[i] : r_tgt[i] - r_cur[i];
        end
        w_max01 = (w_d[1] > w_d[0]) ? w_d[1] : w_d[0];
        w_maxd  = (w_d[2] > w_max01) ? w_d[2] : w_max01;
    end

    assign w_req.start    = w_accept && w_need_div;
    assign w_req.dividend = (r_task == T_TASK_REL) ? r_fade_rel : r_fade_abs;
    assign w_req.divisor  = w_maxd;

    rpfd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = w_need_div ? S_DIV : S_OUT;
            S_DIV:   if (w_rsp.done) n_state = S_OUT;
            S_OUT:   if (w_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd.ready = (r_state == S_IDLE);
        res.valid = (r_state == S_OUT);
    end

    // item execution: hold the command, run it when the divider is clear
    logic w_exec;
    assign w_exec = (r_state == S_IDLE && w_accept && !w_need_div) ||
                    (r_state == S_DIV && w_rsp.done);

    logic w_all_zero;
    assign w_all_zero = (r_cur[0] == '0) && (r_cur[1] == '0) && (r_cur[2] == '0);

    logic [2:0]  x_mode;
    logic [23:0] x_color;
    logic [1:0]  x_chan;
    logic        x_dir, x_nflag;
    logic [2:0]  x_stepc;
    assign x_mode  = (r_state == S_IDLE) ? cmd.mode : r_mode;
    assign x_color = (r_state == S_IDLE) ? cmd.color : r_color;
    assign x_chan  = (r_state == S_IDLE) ? cmd.channel : r_chan;
    assign x_dir   = (r_state == S_IDLE) ? cmd.direction : r_dir;
    assign x_stepc = (r_state == S_IDLE) ? cmd.step_size : r_stepc;
    assign x_nflag = (r_state == S_IDLE) ? cmd.night : r_nflag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fade_abs   <= 24'd1000;
            r_fade_rel   <= 24'd5000;
            r_day        <= 24'hFFFFFF;
            r_night      <= 24'h404040;
            r_use_day    <= 1'b1;
            r_use_night  <= 1'b1;
            r_min        <= 8'd0;
            r_max        <= 8'd255;
            for (int i = 0; i < 3; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
                r_dlt[i] <= '0;
                r_acc[i] <= '0;
            end
            r_big        <= '0;
            r_step_time  <= '0;
            r_ticks      <= '1;
            r_task       <= T_TASK_IDLE;
            r_started    <= 1'b0;
            r_is_night   <= 1'b0;
            r_last_day   <= '0;
            r_last_night <= '0;
            r_changed    <= 1'b0;
            r_report     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FADE_ABS:  r_fade_abs  <= i_cfg_data;
                    REG_FADE_REL:  r_fade_rel  <= i_cfg_data;
                    REG_DAY:       r_day       <= i_cfg_data;
                    REG_NIGHT:     r_night     <= i_cfg_data;
                    REG_USE_DAY:   r_use_day   <= i_cfg_data[0];
                    REG_USE_NIGHT: r_use_night <= i_cfg_data[0];
                    REG_MIN:       r_min       <= i_cfg_data[7:0];
                    REG_MAX:       r_max       <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_mode  <= cmd.mode;
                r_color <= cmd.color;
                r_chan  <= cmd.channel;
                r_dir   <= cmd.direction;
                r_stepc <= cmd.step_size;
                r_nflag <= cmd.night;
            end
            if (w_exec) begin
                logic v_chg;
                logic v_rep;
                v_chg = 1'b0;
                v_rep = 1'b0;
                case (x_mode)
                    MODE_TICK: begin
                        logic [23:0] v_ticks;
                        logic [7:0]  v_dlt [3];
                        logic [8:0]  v_acc [3];
                        logic [7:0]  v_big;
                        logic [23:0] v_st;
                        logic        v_started;
                        logic [8:0]  v_sum;
                        logic [7:0]  v_n;
                        v_ticks = (r_ticks != '1) ? r_ticks + 1'b1 : r_ticks;
                        v_dlt = r_dlt;
                        v_acc = r_acc;
                        v_big = r_big;
                        v_st  = r_step_time;
                        v_started = r_started;
                        if (r_task == T_TASK_STOP) begin
                            r_task    <= T_TASK_IDLE;
                            v_started = 1'b0;
                            v_rep     = 1'b1;
                        end else if (r_task != T_TASK_IDLE) begin
                            if (!r_started) begin
                                for (int i = 0; i < 3; i++) begin
                                    v_dlt[i] = w_d[i];
                                    v_acc[i] = '0;
                                end
                                v_big = w_maxd;
                                v_st  = w_rsp.quotient;
                                v_started = 1'b1;
                            end
                            if (r_cur[0] == r_tgt[0] && r_cur[1] == r_tgt[1] &&
                                r_cur[2] == r_tgt[2]) begin
                                r_task    <= T_TASK_STOP;
                                v_started = 1'b0;
                            end else if (v_ticks >= v_st) begin
                                for (int i = 0; i < 3; i++) begin
                                    if (r_cur[i] != r_tgt[i]) begin
                                        v_sum = v_acc[i] + {1'b0, v_dlt[i]};
                                        v_acc[i] = v_sum;
                                        if (v_sum >= {1'b0, v_big}) begin
                                            v_n = (r_cur[i] < r_tgt[i]) ? r_cur[i] + 1'b1
                                                                         : r_cur[i] - 1'b1;
                                            if (v_n > r_max) v_n = r_max;
                                            if (v_n < r_min) v_n = r_min;
                                            r_cur[i] <= v_n;
                                            v_acc[i] = v_sum - {1'b0, v_big};
                                            v_chg = 1'b1;
                                        end
                                    end
                                end
                                if (v_chg) v_ticks = '0;
                            end
                        end
                        r_ticks     <= v_ticks;
                        r_dlt       <= v_dlt;
                        r_acc       <= v_acc;
                        r_big       <= v_big;
                        r_step_time <= v_st;
                        r_started   <= v_started;
                    end
                    MODE_ON: begin
                        logic [23:0] v_c;
                        if (r_is_night) v_c = r_use_night ? r_night : r_last_night;
                        else            v_c = r_use_day ? r_day : r_last_day;
                        r_tgt[0] <= v_c[23:16];
                        r_tgt[1] <= v_c[15:8];
                        r_tgt[2] <= v_c[7:0];
                        r_task    <= T_TASK_ON;
                        r_started <= 1'b0;
                    end
                    MODE_OFF: begin
                        // save the color unless already dark or switching off
                        if (r_task != T_TASK_OFF && !w_all_zero) begin
                            if (r_is_night) r_last_night <= {r_cur[0], r_cur[1], r_cur[2]};
                            else            r_last_day   <= {r_cur[0], r_cur[1], r_cur[2]};
                        end
                        for (int i = 0; i < 3; i++) r_tgt[i] <= '0;
                        r_task    <= T_TASK_OFF;
                        r_started <= 1'b0;
                    end
                    MODE_SET: begin
                        r_tgt[0] <= x_color[23:16];
                        r_tgt[1] <= x_color[15:8];
                        r_tgt[2] <= x_color[7:0];
                        r_task    <= T_TASK_SET;
                        r_started <= 1'b0;
                    end
                    MODE_REL: begin
                        if (x_stepc == '0) begin
                            r_task    <= T_TASK_STOP;
                            r_started <= 1'b0;
                        end else if (x_chan != 2'd3) begin
                            for (int i = 0; i < 3; i++) begin
                                r_tgt[i] <= (x_chan == 2'(i)) ? (x_dir ? r_max : r_min)
                                                               : r_cur[i];
                            end
                            r_task    <= T_TASK_REL;
                            r_started <= 1'b0;
                        end
                    end
                    MODE_NIGHT: r_is_night <= x_nflag;
                    default: ;
                endcase
                r_changed <= v_chg;
                r_report  <= v_rep;
            end
        end
    end

    assign res.red            = r_cur[0];
    assign res.green          = r_cur[1];
    assign res.blue           = r_cur[2];
    assign res.levels_changed = r_changed;
    assign res.status_report  = r_report;
    assign res.light_on       = !w_all_zero;
    assign res.busy_res       = r_started;
endmodule

/* rtl/rpfd_div.sv */
// ----------------------------------------------------------------------------
// rpfd_div: serial restoring divider
// 24-bit by 8-bit, one quotient bit per cycle; divisor zero gives the dividend.
// ----------------------------------------------------------------------------
module rpfd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpfd_pkg::t_div_req i_req,
    output rpfd_pkg::t_div_rsp o_rsp
);
    import rpfd_pkg::*;

    localparam int unsigned CntW = $clog2(TimeW + 1);

    logic [TimeW-1:0]  r_quo;
    logic [LevelW:0]   r_rem;
    logic [LevelW-1:0] r_dvs;
    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [LevelW:0]   w_shift;
    logic [LevelW:0]   w_diff;

    assign w_shift = {r_rem[LevelW-1:0], r_quo[TimeW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_dvs <= i_req.divisor;
                r_cnt <= CntW'(TimeW);
                // a zero divisor passes the dividend straight through
                r_busy <= (i_req.divisor != '0);
                r_done <= (i_req.divisor == '0);
            end else if (r_busy) begin
                if (!w_diff[LevelW]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[TimeW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[TimeW-2:0], 1'b0};
                end
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CntW'(1));
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
